// ===== hw/rtl/tddl_pkg.sv =====
// Package: shared widths, codes and control/status types for the divisor lister.
`default_nettype none
package tddl_pkg;

  localparam int NUMBER_BITS = 12;
  localparam int IN_W        = 12;
  localparam int DIV_W       = 12;
  localparam int CNT_W       = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;
  localparam int MAX_RESULTS = 46;
  localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] VERDICT_ZERO      = 2'd0;
  localparam logic [1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;

  localparam logic [1:0] EMIT_ZERO  = 2'd0;
  localparam logic [1:0] EMIT_PRIME = 2'd1;
  localparam logic [1:0] EMIT_MID   = 2'd2;
  localparam logic [1:0] EMIT_LAST  = 2'd3;

  typedef logic [NUMBER_BITS-1:0] num_t;
  typedef logic [NUMBER_BITS:0]   num1_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_step;
    logic       next_cand;
    logic       take;
    logic       emit;
    logic [1:0] emit_sel;
  } cmd_t;

  typedef struct packed {
    logic num_zero;
    logic num_small;
    logic div_last;
    logic divides;
    logic cand_end;
    logic cap;
    logic pend_vld;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tddl_ctrl.sv =====
// Controller: sequences load, per-candidate serial remainder and result emission.
`default_nettype none
module tddl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tddl_pkg::sts_t sts,
  output tddl_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_NEXT  = 3'd3;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts.num_zero) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tddl_pkg::EMIT_ZERO;
          state_nxt    = ST_IDLE;
        end else if (sts.num_small) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tddl_pkg::EMIT_PRIME;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.divides) begin
            cmd.take = 1'b1;
            if (sts.pend_vld) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = tddl_pkg::EMIT_MID;
            end
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.cand_end || sts.cap) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = sts.pend_vld ? tddl_pkg::EMIT_LAST : tddl_pkg::EMIT_PRIME;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.next_cand = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tddl_dp.sv =====
// Datapath: number and candidate registers, serial restoring remainder, pending divisor, result register.
`default_nettype none
module tddl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tddl_pkg::IN_W-1:0]   in_number,
  input  wire tddl_pkg::cmd_t              cmd,
  output tddl_pkg::sts_t                   sts,
  output logic                             out_valid,
  output logic [1:0]                       out_verdict,
  output logic [tddl_pkg::DIV_W-1:0]       out_divisor,
  output logic                             out_last
);

  tddl_pkg::num_t                   num_r;
  tddl_pkg::num_t                   cand_r;
  tddl_pkg::num_t                   rem_r;
  tddl_pkg::num_t                   rem_nxt;
  tddl_pkg::num_t                   pend_r;
  logic [tddl_pkg::CNT_W-1:0]       cnt_r;
  logic [tddl_pkg::FCNT_W-1:0]      fcnt_r;
  logic                             pend_vld_r;
  tddl_pkg::num1_t                  rem_sh;
  tddl_pkg::num1_t                  rem_sub;
  logic                             out_valid_r;
  logic [1:0]                       out_verdict_r;
  logic [tddl_pkg::DIV_W-1:0]       out_divisor_r;
  logic                             out_last_r;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, num_r[cnt_r]};
  assign rem_sub = rem_sh - {1'b0, cand_r};
  assign rem_nxt = (rem_sh >= {1'b0, cand_r}) ? rem_sub[tddl_pkg::NUMBER_BITS-1:0]
                                               : rem_sh[tddl_pkg::NUMBER_BITS-1:0];

  always_comb begin
    sts.num_zero  = (num_r == '0);
    sts.num_small = (num_r == tddl_pkg::NUMBER_BITS'(1)) ||
                    (num_r == tddl_pkg::NUMBER_BITS'(2));
    sts.div_last  = (cnt_r == '0);
    sts.divides   = (rem_nxt == '0);
    sts.cand_end  = (({1'b0, cand_r} + tddl_pkg::num1_t'(1)) == {1'b0, num_r});
    sts.cap       = (fcnt_r == tddl_pkg::FCNT_W'(tddl_pkg::MAX_RESULTS));
    sts.pend_vld  = pend_vld_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= in_number[tddl_pkg::NUMBER_BITS-1:0];
      cand_r <= tddl_pkg::NUMBER_BITS'(2);
    end else if (cmd.next_cand) begin
      cand_r <= cand_r + tddl_pkg::NUMBER_BITS'(1);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= tddl_pkg::CNT_W'(tddl_pkg::NUMBER_BITS - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - tddl_pkg::CNT_W'(1);
    end
    if (cmd.take) begin
      pend_r <= cand_r;
    end
    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        tddl_pkg::EMIT_ZERO: begin
          out_verdict_r <= tddl_pkg::VERDICT_ZERO;
          out_divisor_r <= '0;
          out_last_r    <= 1'b1;
        end
        tddl_pkg::EMIT_PRIME: begin
          out_verdict_r <= tddl_pkg::VERDICT_PRIME;
          out_divisor_r <= '0;
          out_last_r    <= 1'b1;
        end
        tddl_pkg::EMIT_MID: begin
          out_verdict_r <= tddl_pkg::VERDICT_COMPOSITE;
          out_divisor_r <= tddl_pkg::DIV_W'(pend_r);
          out_last_r    <= 1'b0;
        end
        default: begin
          out_verdict_r <= tddl_pkg::VERDICT_COMPOSITE;
          out_divisor_r <= tddl_pkg::DIV_W'(pend_r);
          out_last_r    <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        pend_vld_r <= 1'b0;
        fcnt_r     <= '0;
      end else if (cmd.take) begin
        pend_vld_r <= 1'b1;
        fcnt_r     <= fcnt_r + tddl_pkg::FCNT_W'(1);
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_divisor = out_divisor_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/trial_division_divisor_lister.sv =====
// Top level: trial-division primality tester that lists proper divisors.
//
// Input: present in_number with start high; the item is taken at an edge with
// start high and busy low. busy stays high until the last result is issued.
// Output: each result shows on out_verdict/out_divisor/out_last for one cycle
// with out_valid high; the receiver cannot stall, results are never held.
// Zero gives one zero verdict; one and two give one prime verdict.
// Otherwise every candidate 2..n-1 is tried with a serial restoring remainder
// that walks all NUMBER_BITS dividend bits, then the candidate is advanced.
// Divisors come out in rising order; each is issued once the next one is found,
// the largest at the end of the scan marked last; a prime gives one prime verdict.
// Zero, one and two are settled without any remainder step. The remainder unit sets the rate.
// Reset (rst_n low, synchronous) returns to idle and drops any item in work.
`default_nettype none
module trial_division_divisor_lister (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [tddl_pkg::IN_W-1:0] in_number,
  output logic                           out_valid,
  output logic [1:0]                     out_verdict,
  output logic [tddl_pkg::DIV_W-1:0]     out_divisor,
  output logic                           out_last
);

  tddl_pkg::cmd_t cmd;
  tddl_pkg::sts_t sts;

  tddl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tddl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_number   (in_number),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_verdict (out_verdict),
    .out_divisor (out_divisor),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

// ===== verif/tb_trial_division_divisor_lister.sv =====
// Testbench for trial_division_divisor_lister: directed table and random items vs predictor.
`timescale 1ns / 1ps
module tb_trial_division_divisor_lister;

  typedef struct packed {
    logic [1:0]                 verdict;
    logic [tddl_pkg::DIV_W-1:0] divisor;
    logic                       last;
  } divisor_result_t;

  typedef struct packed {
    tddl_pkg::num_t number;
    logic           typed;
    logic [1:0]     verdict;
  } number_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_ITEMS  = 100;

  // typed rows carry their single expected verdict; the rest go to the predictor
  number_row_t directed_rows [DIRECTED_ROWS] = '{
    '{12'd0,    1'b1, tddl_pkg::VERDICT_ZERO},
    '{12'd1,    1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd2,    1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd3,    1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd4,    1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd5,    1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd6,    1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd12,   1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd36,   1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd97,   1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd128,  1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd255,  1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd256,  1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd1024, 1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd2048, 1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd2310, 1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd3960, 1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd4093, 1'b1, tddl_pkg::VERDICT_PRIME},
    '{12'd4094, 1'b0, tddl_pkg::VERDICT_ZERO},
    '{12'd4095, 1'b0, tddl_pkg::VERDICT_ZERO}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [tddl_pkg::IN_W-1:0]  in_number;
  logic                       out_valid;
  logic [1:0]                 out_verdict;
  logic [tddl_pkg::DIV_W-1:0] out_divisor;
  logic                       out_last;

  divisor_result_t due_results[$];
  divisor_result_t want;
  int              mismatches = 0;

  trial_division_divisor_lister uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_verdict(out_verdict),
    .out_divisor(out_divisor),
    .out_last   (out_last)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  task automatic list_divisors(input tddl_pkg::num_t n);
    int found;
    int cand;
    int value;
    found = 0;
    value = int'(n);
    if (value == 0) begin
      due_results.push_back('{tddl_pkg::VERDICT_ZERO, '0, 1'b1});
    end else if (value <= 2) begin
      due_results.push_back('{tddl_pkg::VERDICT_PRIME, '0, 1'b1});
    end else begin
      for (cand = 2; cand < value && found < tddl_pkg::MAX_RESULTS; cand++) begin
        if (value % cand == 0) begin
          due_results.push_back('{tddl_pkg::VERDICT_COMPOSITE,
                                  tddl_pkg::DIV_W'(cand), 1'b0});
          found++;
        end
      end
      if (found == 0) due_results.push_back('{tddl_pkg::VERDICT_PRIME, '0, 1'b1});
      else due_results[due_results.size()-1].last = 1'b1;
    end
  endtask

  task automatic issue_number(input tddl_pkg::num_t n, input int gap, input logic typed,
                              input logic [1:0] verdict);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) due_results.push_back('{verdict, '0, 1'b1});
    else list_divisors(n);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected item: verdict %0d divisor %0d last %0b",
                                out_verdict, out_divisor, out_last));
      end else begin
        want = due_results.pop_front();
        if (out_verdict !== want.verdict || out_divisor !== want.divisor ||
            out_last !== want.last)
          flag_mismatch($sformatf(
            "mismatch: expected verdict %0d divisor %0d last %0b, got %0d %0d %0b",
            want.verdict, want.divisor, want.last, out_verdict, out_divisor, out_last));
      end
    end
  end

  initial begin
    tddl_pkg::num_t n;
    logic steady;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_number = '0;
    steady    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_number(directed_rows[i].number, $urandom_range(0, 8),
                   directed_rows[i].typed, directed_rows[i].verdict);

    // mostly small numbers to keep the scan short; a few over the full range
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 10 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i % 25 == 0) n = tddl_pkg::num_t'($urandom_range(0, 4095));
      else if (i % 5 == 0) n = tddl_pkg::num_t'($urandom_range(0, 1023));
      else n = tddl_pkg::num_t'($urandom_range(0, 127));
      issue_number(n, steady ? 0 : $urandom_range(0, 8), 1'b0, tddl_pkg::VERDICT_ZERO);
    end
    start <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
